// ===== rtl/mcis_pkg.sv =====
// Shared types and constants for the matrix core issue sequencer.
// No dependencies; imported by mcis_step and the top level.
package mcis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int PROG_DEPTH = 1024;
    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int PC_W       = $clog2(PROG_DEPTH);
    localparam int DW_W       = 9;
    localparam int PL_W       = 11;

    // control state codes
    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_READY  = 4'd1;
    localparam logic [3:0] ST_NEXT   = 4'd2;
    localparam logic [3:0] ST_STOP   = 4'd3;
    localparam logic [3:0] ST_ACCESS = 4'd4;
    localparam logic [3:0] ST_P0XX   = 4'd5;
    localparam logic [3:0] ST_P01X   = 4'd6;
    localparam logic [3:0] ST_PX0X   = 4'd7;
    localparam logic [3:0] ST_PXX0   = 4'd8;
    localparam logic [3:0] ST_PX01   = 4'd9;
    localparam logic [3:0] ST_P012   = 4'd10;

    // instruction classes
    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_UNIT  = 2'd1;
    localparam logic [1:0] CLS_MEM   = 2'd2;
    localparam logic [1:0] CLS_HALT  = 2'd3;

    // configuration register indexes
    localparam logic REG_DIAG_WIDTH = 1'b0;
    localparam logic REG_PROG_LEN   = 1'b1;

    typedef struct packed {
        logic [3:0]       ctrl;
        logic [PC_W-1:0]  pc;
        logic [CNT_W-1:0] diag;
        logic             overrun;
    } seq_state_t;

    typedef struct packed {
        logic [DW_W-1:0] diag_width;
        logic [PL_W-1:0] program_length;
    } seq_cfg_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [6:0]       pad;
        logic [CNT_W-1:0] diag_step;
        logic             overrun_error;
        logic             done_res;
        logic             advanced;
        logic [PC_W-1:0]  prog_counter;
        logic [3:0]       ctrl_state;
    } result_t;

endpackage

// ===== rtl/mcis_step.sv =====
// Next-state logic for one tick of the issue sequencer.
// Depends on mcis_pkg.
module mcis_step
(
    input  mcis_pkg::seq_state_t cur,
    input  mcis_pkg::seq_cfg_t   cfg,
    input  logic [1:0]           inst_class,
    input  logic                 next_is_unit,
    output mcis_pkg::seq_state_t nxt,
    output logic                 advanced
);
    import mcis_pkg::*;

    logic [DW_W-1:0]  width_eff;
    logic [PL_W-1:0]  len_eff;
    logic [CNT_W-1:0] last_step;
    logic [PL_W-1:0]  pc_inc;
    logic             has_next;
    logic             nu;
    logic             at_end;
    logic [3:0]       ns;
    logic [CNT_W-1:0] nc;
    logic             adv;

    always_comb
    begin
        // clamp registers to their working range
        if (cfg.diag_width == '0)
            width_eff = DW_W'(1);
        else if (cfg.diag_width > DW_W'(MAX_WIDTH))
            width_eff = DW_W'(MAX_WIDTH);
        else
            width_eff = cfg.diag_width;

        if (cfg.program_length == '0)
            len_eff = PL_W'(1);
        else if (cfg.program_length > PL_W'(PROG_DEPTH))
            len_eff = PL_W'(PROG_DEPTH);
        else
            len_eff = cfg.program_length;
    end

    assign last_step = CNT_W'(width_eff - DW_W'(1));
    assign pc_inc    = PL_W'(cur.pc) + PL_W'(1);
    assign has_next  = pc_inc < len_eff;
    assign nu        = next_is_unit && has_next;
    assign at_end    = cur.diag == last_step;

    always_comb
    begin
        ns  = cur.ctrl;
        nc  = cur.diag;
        adv = 1'b0;
        unique case (cur.ctrl)
            ST_INIT:
                ns = ST_READY;
            ST_READY:
            begin
                unique case (inst_class)
                    CLS_UNIT:
                    begin
                        ns = ST_P0XX;
                        nc = '0;
                    end
                    CLS_MEM:
                    begin
                        ns = ST_ACCESS;
                        nc = '0;
                    end
                    CLS_HALT:  ns = ST_STOP;
                    CLS_OTHER: ns = ST_NEXT;
                    default:   ns = ST_NEXT;
                endcase
            end
            ST_NEXT:
            begin
                adv = 1'b1;
                ns  = ST_READY;
            end
            ST_STOP:
                ns = ST_STOP;
            ST_ACCESS, ST_PXX0:
            begin
                if (at_end)
                    ns = ST_NEXT;
                else
                    nc = cur.diag + CNT_W'(1);
            end
            ST_P0XX, ST_P01X, ST_P012:
            begin
                if (at_end)
                begin
                    if (nu)
                    begin
                        ns  = (cur.ctrl == ST_P0XX) ? ST_P01X : ST_P012;
                        adv = 1'b1;
                    end
                    else
                    begin
                        ns = (cur.ctrl == ST_P0XX) ? ST_PX0X : ST_PX01;
                    end
                    nc = '0;
                end
                else
                begin
                    nc = cur.diag + CNT_W'(1);
                end
            end
            ST_PX0X, ST_PX01:
            begin
                if (at_end)
                begin
                    ns = ST_PXX0;
                    nc = '0;
                end
                else
                begin
                    nc = cur.diag + CNT_W'(1);
                end
            end
            default:
                ns = ST_STOP;
        endcase
    end

    always_comb
    begin
        nxt      = cur;
        advanced = 1'b0;
        priority if (cur.overrun)
        begin
            nxt = cur;
        end
        else if (adv && !has_next)
        begin
            nxt.overrun = 1'b1;
        end
        else
        begin
            nxt.ctrl = ns;
            nxt.diag = nc;
            if (adv)
                nxt.pc = pc_inc[PC_W-1:0];
            advanced = adv;
        end
    end

endmodule

// ===== rtl/matrix_core_issue_sequencer_unit.sv =====
// Top level of the matrix core issue sequencer: tick stream in, status word out,
// APB register port. Depends on mcis_pkg and mcis_step.
//
// Usage:
//   Slave stream (s_*): one word per clock tick of the sequenced program,
//   carrying the class of the instruction at the program counter and whether
//   the instruction after it is a unit operation.
//   Master stream (m_*): one status word per accepted tick, giving the control
//   state, program counter, advance strobe, stop flag, overrun flag and
//   diagonal step as they stand after that tick.
//   APB port: diag_width at 0x0, program_length at 0x4; write only while the
//   block is idle.
// Each accepted word's status word is registered (output or skid register).
//   Throughput: one word per cycle while m_tready is high; each tick is one
//   mcis_step pass between the state registers and the output register.
// Stalls: a two-entry output buffer (output register plus skid register)
//   keeps s_tready high for one more word after m_tready drops; it falls only
//   when both entries are full.
// Reset: state goes to init with program counter, diagonal step and overrun
//   flag cleared; diag_width returns to 16 and program_length to 1024.
// Once overrun is flagged, all sequencer state freezes until reset.
module matrix_core_issue_sequencer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: [1:0] inst_class, [2] next_is_unit, [7:3] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // master stream: [3:0] ctrl_state, [13:4] prog_counter, [14] advanced,
    // [15] done_res, [16] overrun_error, [24:17] diag_step, [31:25] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcis_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    seq_cfg_t   cfg_reg;
    logic       adv;
    logic       s_accept;
    logic       cfg_write;
    result_t    res_new;
    result_t    out_reg;
    result_t    skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_DIAG_WIDTH: prdata = 32'(cfg_reg.diag_width);
            REG_PROG_LEN:   prdata = 32'(cfg_reg.program_length);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diag_width     <= DW_W'(16);
            cfg_reg.program_length <= PL_W'(1024);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_DIAG_WIDTH)
                cfg_reg.diag_width <= pwdata[DW_W-1:0];
            else
                cfg_reg.program_length <= pwdata[PL_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    // Take a new word whenever the skid entry is free.
    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    mcis_step u_step
    (
        .cur          (state_reg),
        .cfg          (cfg_reg),
        .inst_class   (s_tdata[1:0]),
        .next_is_unit (s_tdata[2]),
        .nxt          (state_next),
        .advanced     (adv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.ctrl    <= ST_INIT;
            state_reg.pc      <= '0;
            state_reg.diag    <= '0;
            state_reg.overrun <= 1'b0;
        end
        else if (s_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Status word reflects the state after this tick.
    always_comb
    begin
        res_new               = '0;
        res_new.ctrl_state    = state_next.ctrl;
        res_new.prog_counter  = state_next.pc;
        res_new.advanced      = adv;
        res_new.done_res      = state_next.ctrl == ST_STOP;
        res_new.overrun_error = state_next.overrun;
        res_new.diag_step     = state_next.diag;
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
            begin
                // output slot frees: refill from skid first, else from the new word
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= s_accept;
                end
            end
            else if (s_accept)
            begin
                // hold the new word aside while the receiver stalls
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (s_accept)
                out_reg <= res_new;
        end
        if (out_valid_reg && !m_tready && s_accept)
            skid_reg <= res_new;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // ---------------- assertions ----------------
    a_overrun_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.overrun |=> state_reg.overrun)
        else $error("overrun flag cleared without reset");

    a_overrun_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.overrun |=> $stable(state_reg.ctrl) && $stable(state_reg.pc)
                              && $stable(state_reg.diag))
        else $error("sequencer state moved while frozen");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s_accept |=> $stable(state_reg))
        else $error("sequencer state moved without an accepted word");

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied while output register empty");

endmodule
